FILE: design/assert_macros.svh
// assertion helpers used by the aligner design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clk edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked in the same cycle
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: design/spfa_pkg.sv
package spfa_pkg;

    localparam int SYNC_W    = 20;
    localparam int WIN_W     = 64;
    localparam int BYTE_W    = 8;
    localparam int FRAME_W   = 32;
    localparam int SAMPLE_W  = 12;
    localparam int OFFSET_W  = 6;
    localparam int SEEN_W    = 4;

    localparam int SEARCH_TOP    = 44;
    localparam int SEARCH_BOTTOM = 12;

    localparam logic [OFFSET_W-1:0] SHIFT_BASE   = 6'd45;
    localparam logic [OFFSET_W-1:0] OFFSET_FLOOR = 6'd12;
    localparam logic [SEEN_W-1:0]   WINDOW_BYTES = 4'd8;

    localparam logic [SYNC_W-1:0] SYNC_PATTERN_RST = 20'h30009;
    localparam logic [SYNC_W-1:0] SYNC_MASK_RST    = 20'hF000F;

    // configuration register indexes
    localparam logic REG_SYNC_PATTERN = 1'b0;
    localparam logic REG_SYNC_MASK    = 1'b1;

    // frame status codes
    localparam logic [1:0] ST_SYNC_OK     = 2'd0;
    localparam logic [1:0] ST_SYNC_MISS   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND   = 2'd2;

    // frame request handed from the alignment stage to the extraction stage
    typedef struct packed {
        logic [WIN_W-1:0]    window;
        logic [OFFSET_W-1:0] offset;
        logic                not_found;
    } frame_req_t;

endpackage

FILE: design/sync_pattern_frame_aligner.sv
// sync_pattern_frame_aligner: word alignment of one serial ADC link
// input channel: data_byte (stream bits, msb first) and first_byte (start of a
//   capture, clears the alignment) under in_valid / in_ready
// config port: cfg_write, cfg_addr (0 sync_pattern, 1 sync_mask), cfg_data;
//   write only while no item is in flight
// output channel: sample_high, sample_low, frame_status, bit_shift under
//   out_valid / out_ready
// the eighth byte of a capture triggers the sync search and gives the first
//   result; after a lock every fourth byte gives a frame, after a failed
//   search one not-found result is given and then nothing until first_byte
// pipeline: the byte that causes a result passes the alignment/search stage,
//   then the frame extraction stage into the output register
// throughput: one byte per clock while in_ready is high
// reset: window, counters and alignment cleared, registers back to defaults
// receiver stall: the output register holds the result, one more frame can
//   wait in the extraction stage, and in_ready drops only when both are full
`include "assert_macros.svh"

module sync_pattern_frame_aligner
    import spfa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_write,
    input  logic                cfg_addr,
    input  logic [SYNC_W-1:0]   cfg_data,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic                first_byte,

    output logic                out_valid,
    input  logic                out_ready,
    output logic [SAMPLE_W-1:0] sample_high,
    output logic [SAMPLE_W-1:0] sample_low,
    output logic [1:0]          frame_status,
    output logic [OFFSET_W-1:0] bit_shift
);

    // configuration registers
    logic [SYNC_W-1:0] sync_pattern_reg;
    logic [SYNC_W-1:0] sync_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_pattern_reg <= SYNC_PATTERN_RST;
            sync_mask_reg    <= SYNC_MASK_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_addr)
                REG_SYNC_PATTERN: sync_pattern_reg <= cfg_data;
                REG_SYNC_MASK:    sync_mask_reg    <= cfg_data;
                default:          sync_pattern_reg <= sync_pattern_reg;
            endcase
        end
    end

    // alignment state
    logic [WIN_W-1:0]    bit_window_reg,   bit_window_next;
    logic [SEEN_W-1:0]   bytes_seen_reg,   bytes_seen_next;
    logic [1:0]          frame_phase_reg,  frame_phase_next;
    logic [OFFSET_W-1:0] match_offset_reg, match_offset_next;
    logic                align_locked_reg, align_locked_next;
    logic                align_failed_reg, align_failed_next;

    // pipeline registers
    logic       s1_valid_reg;
    frame_req_t s1_req_reg;
    frame_req_t s1_req_next;
    logic       s1_load;
    logic       s1_ready;
    logic       in_fire;

    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] sample_high_reg;
    logic [SAMPLE_W-1:0] sample_low_reg;
    logic [1:0]          frame_status_reg;
    logic [OFFSET_W-1:0] bit_shift_reg;

    // handshake: the ready chain runs back from the output register
    assign s1_ready = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_ready;
    assign in_fire  = in_valid && in_ready;

    // sync search over the updated window
    logic [SEARCH_TOP:SEARCH_BOTTOM] match_vec;
    logic [OFFSET_W-1:0]             found_offset;
    logic                            found_any;

    always_comb
    begin
        for (int i = SEARCH_BOTTOM; i <= SEARCH_TOP; i++)
        begin
            match_vec[i] = ((bit_window_next[i +: SYNC_W] & sync_mask_reg)
                            == sync_pattern_reg);
        end
    end

    // highest matching offset wins
    always_comb
    begin
        found_offset = '0;
        found_any    = 1'b0;
        for (int i = SEARCH_BOTTOM; i <= SEARCH_TOP; i++)
        begin
            if (match_vec[i])
            begin
                found_offset = OFFSET_W'(i);
                found_any    = 1'b1;
            end
        end
    end

    // next alignment state for the incoming item
    logic [WIN_W-1:0]    win_base;
    logic [SEEN_W-1:0]   seen_base;
    logic [1:0]          phase_base;
    logic [OFFSET_W-1:0] offset_base;
    logic                locked_base;
    logic                failed_base;

    always_comb
    begin
        if (first_byte)
        begin
            win_base    = '0;
            seen_base   = '0;
            phase_base  = '0;
            offset_base = '0;
            locked_base = 1'b0;
            failed_base = 1'b0;
        end
        else
        begin
            win_base    = bit_window_reg;
            seen_base   = bytes_seen_reg;
            phase_base  = frame_phase_reg;
            offset_base = match_offset_reg;
            locked_base = align_locked_reg;
            failed_base = align_failed_reg;
        end

        bit_window_next   = {win_base[WIN_W-BYTE_W-1:0], data_byte};
        bytes_seen_next   = seen_base;
        frame_phase_next  = phase_base;
        match_offset_next = offset_base;
        align_locked_next = locked_base;
        align_failed_next = failed_base;
        s1_load           = 1'b0;

        s1_req_next.window    = bit_window_next;
        s1_req_next.offset    = offset_base;
        s1_req_next.not_found = 1'b0;

        if (failed_base)
        begin
            s1_load = 1'b0;
        end
        else if (locked_base)
        begin
            frame_phase_next = phase_base + 2'd1;
            s1_load          = (frame_phase_next == 2'd0);
        end
        else
        begin
            if (seen_base < WINDOW_BYTES)
            begin
                bytes_seen_next = seen_base + 4'd1;
            end
            if (bytes_seen_next == WINDOW_BYTES)
            begin
                s1_load = 1'b1;
                if (found_any)
                begin
                    align_locked_next  = 1'b1;
                    frame_phase_next   = 2'd0;
                    match_offset_next  = found_offset;
                    s1_req_next.offset = found_offset;
                end
                else
                begin
                    align_failed_next     = 1'b1;
                    match_offset_next     = '0;
                    s1_req_next.offset    = '0;
                    s1_req_next.not_found = 1'b1;
                end
            end
        end
    end

    // state and alignment stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_window_reg   <= '0;
            bytes_seen_reg   <= '0;
            frame_phase_reg  <= '0;
            match_offset_reg <= '0;
            align_locked_reg <= 1'b0;
            align_failed_reg <= 1'b0;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                bit_window_reg   <= bit_window_next;
                bytes_seen_reg   <= bytes_seen_next;
                frame_phase_reg  <= frame_phase_next;
                match_offset_reg <= match_offset_next;
                align_locked_reg <= align_locked_next;
                align_failed_reg <= align_failed_next;
            end
            if (in_fire && s1_load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_ready)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && s1_load)
        begin
            s1_req_reg <= s1_req_next;
        end
    end

    // frame extraction and sync check
    logic [OFFSET_W-1:0] frame_sh;
    logic [FRAME_W-1:0]  frame;
    logic                sync_ok;

    assign frame_sh = s1_req_reg.offset - OFFSET_FLOOR;
    assign frame    = FRAME_W'(s1_req_reg.window >> frame_sh);
    assign sync_ok  = ((frame & {sync_mask_reg, 12'b0}) == {sync_pattern_reg, 12'b0});

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && s1_valid_reg)
        begin
            if (s1_req_reg.not_found)
            begin
                sample_high_reg  <= '0;
                sample_low_reg   <= '0;
                frame_status_reg <= ST_NOT_FOUND;
                bit_shift_reg    <= '0;
            end
            else
            begin
                sample_high_reg  <= sync_ok ? frame[27:16] : '0;
                sample_low_reg   <= sync_ok ? frame[11:0] : '0;
                frame_status_reg <= sync_ok ? ST_SYNC_OK : ST_SYNC_MISS;
                bit_shift_reg    <= SHIFT_BASE - s1_req_reg.offset;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_high  = sample_high_reg;
    assign sample_low   = sample_low_reg;
    assign frame_status = frame_status_reg;
    assign bit_shift    = bit_shift_reg;

    // checks on the alignment state
    `ASSERT_ALWAYS(a_lock_fail_excl, !(align_locked_reg && align_failed_reg),
        "alignment both locked and failed")
    `ASSERT_IMPLY(a_offset_range, align_locked_reg,
        (match_offset_reg >= OFFSET_FLOOR) && (match_offset_reg <= 6'd44),
        "locked offset outside search range")
    `ASSERT_IMPLY(a_fail_reports, $rose(align_failed_reg),
        s1_valid_reg && s1_req_reg.not_found,
        "failed search without a not-found frame")
    `ASSERT_ALWAYS(a_seen_bound, bytes_seen_reg <= WINDOW_BYTES,
        "byte count past window size")

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import spfa_pkg::*;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              first;
    } stream_byte_t;

    typedef struct {
        logic [SAMPLE_W-1:0] sample_high;
        logic [SAMPLE_W-1:0] sample_low;
        logic [1:0]          status;
        logic [OFFSET_W-1:0] shift;
    } frame_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_write = 1'b0;
    logic                cfg_addr = REG_SYNC_PATTERN;
    logic [SYNC_W-1:0]   cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [BYTE_W-1:0]   data_byte = '0;
    logic                first_byte = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [SAMPLE_W-1:0] sample_high;
    logic [SAMPLE_W-1:0] sample_low;
    logic [1:0]          frame_status;
    logic [OFFSET_W-1:0] bit_shift;

    // aligner state tracked by the testbench
    logic [WIN_W-1:0]    stream_win = '0;
    logic [SEEN_W-1:0]   bytes_in = '0;
    logic [1:0]          frame_cnt = '0;
    logic [OFFSET_W-1:0] lock_off = '0;
    logic                locked = 1'b0;
    logic                search_failed = 1'b0;
    logic [SYNC_W-1:0]   cfg_pattern = SYNC_PATTERN_RST;
    logic [SYNC_W-1:0]   cfg_mask = SYNC_MASK_RST;

    stream_byte_t tx_bytes[$];
    frame_t       frames_due[$];
    frame_t       want;

    int bytes_queued = 0;
    int bytes_accepted = 0;
    int errors = 0;
    int settings_used = 0;
    int ok_seen = 0;
    int miss_seen = 0;
    int nf_seen = 0;
    int tx_gap = 0;
    int tx_calm = 0;
    int rx_gap = 0;
    int rx_calm = 0;
    int hold_left = 0;
    bit rx_hold_req = 1'b0;
    bit rx_hold_done = 1'b0;

    sync_pattern_frame_aligner u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .first_byte   (first_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample_high  (sample_high),
        .sample_low   (sample_low),
        .frame_status (frame_status),
        .bit_shift    (bit_shift)
    );

    // clock and reset
    always #5 clk = ~clk;

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 999);
        if (r < 600)
            return 0;
        else if (r < 900)
            return $urandom_range(1, 3);
        else if (r < 975)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // frame cut from the window at the locked offset
    function automatic frame_t cut_frame();
        logic [WIN_W-1:0]   shifted;
        logic [FRAME_W-1:0] fr;
        logic [FRAME_W-1:0] m;
        logic [FRAME_W-1:0] p;
        frame_t             f;
        shifted = stream_win >> (lock_off - SEARCH_BOTTOM);
        fr = shifted[FRAME_W-1:0];
        m = {cfg_mask, 12'h000};
        p = {cfg_pattern, 12'h000};
        if ((fr & m) == p)
        begin
            f.sample_high = fr[27:16];
            f.sample_low = fr[11:0];
            f.status = ST_SYNC_OK;
        end
        else
        begin
            f.sample_high = '0;
            f.sample_low = '0;
            f.status = ST_SYNC_MISS;
        end
        f.shift = SHIFT_BASE - lock_off;
        return f;
    endfunction

    // highest offset holding the masked sync pattern
    function automatic bit find_sync();
        logic [WIN_W-1:0] m;
        logic [WIN_W-1:0] p;
        m = {44'd0, cfg_mask};
        p = {44'd0, cfg_pattern};
        for (int o = SEARCH_TOP; o >= SEARCH_BOTTOM; o--)
            if ((stream_win & (m << o)) == (p << o))
            begin
                lock_off = OFFSET_W'(o);
                return 1'b1;
            end
        return 1'b0;
    endfunction

    // update tracked state with one accepted byte, queue any frame it yields
    task automatic track_byte(input logic [BYTE_W-1:0] b, input logic fb);
        frame_t nf;
        if (fb)
        begin
            stream_win = '0;
            bytes_in = '0;
            frame_cnt = '0;
            lock_off = '0;
            locked = 1'b0;
            search_failed = 1'b0;
        end
        stream_win = {stream_win[WIN_W-BYTE_W-1:0], b};
        if (search_failed)
            return;
        if (locked)
        begin
            frame_cnt = frame_cnt + 2'd1;
            if (frame_cnt == 2'd0)
                frames_due.insert(frames_due.size(), cut_frame());
            return;
        end
        if (bytes_in < WINDOW_BYTES)
            bytes_in = bytes_in + 1'b1;
        if (bytes_in < WINDOW_BYTES)
            return;
        if (find_sync())
        begin
            locked = 1'b1;
            frame_cnt = '0;
            frames_due.insert(frames_due.size(), cut_frame());
        end
        else
        begin
            search_failed = 1'b1;
            lock_off = '0;
            nf.sample_high = '0;
            nf.sample_low = '0;
            nf.status = ST_NOT_FOUND;
            nf.shift = '0;
            frames_due.insert(frames_due.size(), nf);
        end
    endtask

    // byte sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            data_byte <= '0;
            first_byte <= 1'b0;
            tx_gap <= 0;
            tx_calm <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                track_byte(data_byte, first_byte);
                bytes_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (tx_gap != 0)
                begin
                    in_valid <= 1'b0;
                    tx_gap <= tx_gap - 1;
                end
                else if (tx_bytes.size() != 0)
                begin
                    in_valid <= 1'b1;
                    data_byte <= tx_bytes[0].data;
                    first_byte <= tx_bytes[0].first;
                    void'(tx_bytes.pop_front());
                    if (tx_calm != 0)
                    begin
                        tx_calm <= tx_calm - 1;
                        tx_gap <= 0;
                    end
                    else
                    begin
                        tx_gap <= pick_gap();
                        if ($urandom_range(0, 63) == 0)
                            tx_calm <= $urandom_range(40, 150);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string what, input logic [SAMPLE_W-1:0] exp_val,
                               input logic [SAMPLE_W-1:0] act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t: %s mismatch, expected %h got %h", $time, what, exp_val, act_val);
            errors++;
        end
    endtask

    // result receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_gap <= 0;
            rx_calm <= 0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (frames_due.size() == 0)
                begin
                    $display("%0t: extra result, expected none got %h %h %0d %0d",
                             $time, sample_high, sample_low, frame_status, bit_shift);
                    errors++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    check_field("sample_high", want.sample_high, sample_high);
                    check_field("sample_low", want.sample_low, sample_low);
                    check_field("frame_status", 12'(want.status), 12'(frame_status));
                    check_field("bit_shift", 12'(want.shift), 12'(bit_shift));
                    case (want.status)
                        ST_SYNC_OK:   ok_seen++;
                        ST_SYNC_MISS: miss_seen++;
                        default:      nf_seen++;
                    endcase
                end
            end
            // long hold on request, otherwise random stalls
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (rx_hold_req && !rx_hold_done)
            begin
                out_ready <= 1'b0;
                hold_left <= 400;
                rx_hold_done <= 1'b1;
            end
            else if (rx_gap != 0)
            begin
                out_ready <= 1'b0;
                rx_gap <= rx_gap - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if (out_valid && out_ready)
                begin
                    if (rx_calm != 0)
                    begin
                        rx_calm <= rx_calm - 1;
                        rx_gap <= 0;
                    end
                    else
                    begin
                        rx_gap <= pick_gap();
                        if ($urandom_range(0, 31) == 0)
                            rx_calm <= $urandom_range(20, 60);
                    end
                end
            end
        end
    end

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic fb);
        stream_byte_t s;
        s.data = b;
        s.first = fb;
        tx_bytes.insert(tx_bytes.size(), s);
        bytes_queued++;
    endtask

    // wait until every byte is taken and every frame has come out
    task automatic wait_idle();
        while (bytes_accepted != bytes_queued || frames_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic addr, input logic [SYNC_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (addr == REG_SYNC_PATTERN)
            cfg_pattern = val;
        else
            cfg_mask = val;
    endtask

    task automatic set_sync(input logic [SYNC_W-1:0] pat, input logic [SYNC_W-1:0] msk);
        wait_idle();
        write_reg(REG_SYNC_PATTERN, pat);
        write_reg(REG_SYNC_MASK, msk);
        settings_used++;
    endtask

    // capture with the sync pattern planted at one offset; later frames
    // carry it with probability hit_pct; fill < 0 gives random bytes
    task automatic queue_locked_capture(input bit mark, input int off, input int frames,
                                        input int extra, input int hit_pct, input int fill);
        logic [BYTE_W-1:0] cap [0:127];
        int n_bytes;
        int n;
        int pos;
        n_bytes = 8 + 4 * (frames - 1) + extra;
        for (int i = 0; i < n_bytes; i++)
            cap[i] = (fill < 0) ? BYTE_W'($urandom) : BYTE_W'(fill);
        for (int k = 0; k < frames; k++)
        begin
            if (k == 0 || $urandom_range(0, 99) < hit_pct)
            begin
                n = 8 + 4 * k;
                for (int i = 0; i < SYNC_W; i++)
                    if (cfg_mask[i])
                    begin
                        pos = 8 * n - 1 - (off + i);
                        cap[pos / 8][7 - pos % 8] = cfg_pattern[i];
                    end
            end
        end
        for (int i = 0; i < n_bytes; i++)
            push_byte(cap[i], mark && i == 0);
    endtask

    task automatic queue_plain_capture(input int len);
        for (int i = 0; i < len; i++)
            push_byte(BYTE_W'($urandom), i == 0);
    endtask

    // mostly well-formed captures, some short or random ones and loose bytes
    task automatic random_traffic(input int budget);
        int start;
        int loose;
        int r;
        int frames;
        int off;
        int fill;
        start = bytes_queued;
        loose = 0;
        while (bytes_queued - start - loose < budget)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
            begin
                frames = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 28)
                                                     : $urandom_range(1, 6);
                r = $urandom_range(0, 9);
                off = (r == 0) ? SEARCH_BOTTOM : (r == 1) ? SEARCH_TOP
                                               : $urandom_range(SEARCH_BOTTOM, SEARCH_TOP);
                r = $urandom_range(0, 19);
                fill = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : -1;
                queue_locked_capture(1'b1, off, frames, $urandom_range(0, 3), 85, fill);
            end
            else if (r < 85)
            begin
                queue_plain_capture($urandom_range(8, 12));
            end
            else if (r < 95)
            begin
                queue_plain_capture($urandom_range(1, 7));
            end
            else
            begin
                r = $urandom_range(1, 6);
                for (int i = 0; i < r; i++)
                    push_byte(BYTE_W'($urandom), 1'b0);
                loose += r;
            end
        end
    endtask

    // stimulus
    initial
    begin
        logic [SYNC_W-1:0] msk;

        wait (rst_n === 1'b1);
        set_sync(SYNC_PATTERN_RST, SYNC_MASK_RST);

        // unmarked capture after reset: two good frames then a broken one
        queue_locked_capture(1'b0, SEARCH_TOP, 2, 0, 100, 8'hFF);
        for (int i = 0; i < 4; i++)
            push_byte(8'h00, 1'b0);
        // capture with no sync anywhere, then a byte that must be ignored
        for (int i = 0; i < 8; i++)
            push_byte(8'h00, i == 0);
        push_byte(8'h5A, 1'b0);
        random_traffic(220);

        // compare nothing: every search locks at the top offset
        set_sync(20'h00000, 20'h00000);
        random_traffic(150);

        // full compare, with a long receiver hold during a long capture
        set_sync(20'hFFFFF, 20'hFFFFF);
        rx_hold_req = 1'b1;
        queue_locked_capture(1'b1, 30, 28, 2, 100, -1);
        random_traffic(150);

        msk = SYNC_W'($urandom);
        set_sync(SYNC_W'($urandom) & msk, msk);
        random_traffic(160);

        // pattern bit outside the mask: never aligns
        set_sync(20'h00001, 20'h0F0F0);
        random_traffic(80);

        set_sync(20'h00000, 20'hFFFFF);
        random_traffic(150);

        msk = SYNC_W'($urandom) | 20'hF000F;
        set_sync(SYNC_W'($urandom) & msk, msk);
        random_traffic(160);

        set_sync(SYNC_PATTERN_RST, SYNC_MASK_RST);
        random_traffic(150);

        wait_idle();
        $display("ran %0d bytes under %0d sync settings, with a long output hold",
                 bytes_accepted, settings_used);
        $display("frames checked: %0d in sync, %0d out of sync, %0d alignment failures",
                 ok_seen, miss_seen, nf_seen);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("timeout with %0d frames still due", frames_due.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/spfa_pkg.sv
design/sync_pattern_frame_aligner.sv
test/tb.sv
